// ----- sv/earliest_free_unit_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Earliest-free unit allocator assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_UNIT_ALLOCATOR_ASSERT_SVH
`define EARLIEST_FREE_UNIT_ALLOCATOR_ASSERT_SVH

// check a property at every rising edge of clk
`define EFUA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition implies a consequence in the next cycle
`define EFUA_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (cons)) else $error(msg);

`endif

// ----- sv/efua_pkg.sv -----
// ----------------------------------------------------------------------------
// efua_pkg
// Shared widths, constants and types of the earliest-free unit allocator.
// ----------------------------------------------------------------------------
package efua_pkg;

	localparam int NUM_UNITS = 4;
	localparam int TIME_W    = 32;
	localparam int USE_W     = 16;
	localparam int IDX_W     = 4;
	localparam int UNIT_W    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [USE_W-1:0]  use_t;
	typedef logic [UNIT_W-1:0] unit_t;

	localparam unit_t LAST_UNIT = UNIT_W'(NUM_UNITS - 1);
	localparam use_t  USE_TIME_RST = USE_W'(1);

	typedef struct packed {
		logic  free;
		logic  better;
		time_t sum;
	} alu_res_t;

endpackage

// ----- sv/efua_alu.sv -----
// ----------------------------------------------------------------------------
// efua_alu
// Shared compare and saturating add unit: tests one operand against the
// request time and the best time so far, and adds the use time to it.
// ----------------------------------------------------------------------------
module efua_alu (
	input  efua_pkg::time_t    cand,
	input  efua_pkg::time_t    now_time,
	input  efua_pkg::time_t    best,
	input  efua_pkg::use_t     use_time,
	output efua_pkg::alu_res_t res
);
	import efua_pkg::*;

	logic [TIME_W:0] full;

	assign full = {1'b0, cand} + {{(TIME_W - USE_W + 1){1'b0}}, use_time};

	always_comb begin
		res.free   = (cand <= now_time);
		res.better = (cand < best);
		res.sum    = full[TIME_W] ? {TIME_W{1'b1}} : full[TIME_W-1:0];
	end

endmodule

// ----- sv/earliest_free_unit_allocator.sv -----
// Flow: an accepted transaction is scanned unit by unit up to the first free one or
//   the last unit, then the pick is booked in an add step that raises m_tvalid.
// Throughput: s_tready stays low from the scan until the add step is done, as the scan
//   loop over the unit store runs through the shared compare/add unit.
// Stalls: the add cycle waits while an earlier result is held off by m_tready.
// Reset: arst_n clears all busy-until times to zero and sets use_time to 1.
// ----------------------------------------------------------------------------
// earliest_free_unit_allocator
// Picks the first free unit in index order, else the earliest busy one,
// and books it for use_time.
// ----------------------------------------------------------------------------
module earliest_free_unit_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  efua_pkg::use_t                    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [efua_pkg::IN_TDATA_W-1:0]   s_tdata,  // [31:0] now_time
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [efua_pkg::OUT_TDATA_W-1:0]  m_tdata   // [31:0] done_time,
	                                                    // [35:32] unit_index
);
	import efua_pkg::*;

	`include "earliest_free_unit_allocator_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	logic [1:0]       state_q;
	time_t            busy_q [NUM_UNITS];
	use_t             use_time_q;
	time_t            now_q;
	time_t            base_q;
	unit_t            idx_q;
	unit_t            pick_q;
	logic             out_valid_q;
	time_t            out_done_q;
	logic [IDX_W-1:0] out_unit_q;

	time_t    cand;
	alu_res_t res;
	logic     out_free;

	assign cand     = (state_q == ST_ADD) ? base_q : busy_q[idx_q];
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - TIME_W - IDX_W){1'b0}}, out_unit_q, out_done_q};

	efua_alu u_alu (
		.cand     (cand),
		.now_time (now_q),
		.best     (base_q),
		.use_time (use_time_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_time_q <= USE_TIME_RST;
		end else if (cfg_we) begin
			use_time_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			for (int i = 0; i < NUM_UNITS; i++) begin
				busy_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_ADD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						now_q   <= s_tdata[TIME_W-1:0];
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (res.free) begin
						base_q  <= now_q;
						pick_q  <= idx_q;
						state_q <= ST_ADD;
					end else begin
						if (idx_q == '0 || res.better) begin
							base_q <= cand;
							pick_q <= idx_q;
						end
						if (idx_q == LAST_UNIT) begin
							state_q <= ST_ADD;
						end else begin
							idx_q <= idx_q + UNIT_W'(1);
						end
					end
				end
				ST_ADD: begin
					if (out_free) begin
						busy_q[pick_q] <= res.sum;
						out_done_q     <= res.sum;
						out_unit_q     <= IDX_W'(pick_q);
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`EFUA_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready,
		state_q == ST_SCAN && idx_q == '0, "transaction accepted without starting scan")
	`EFUA_ASSERT(a_scan_idx_range, state_q != ST_SCAN || idx_q <= LAST_UNIT,
		"scan index beyond last unit")
	`EFUA_ASSERT_NEXT(a_add_delivers, state_q == ST_ADD && out_free,
		m_tvalid && state_q == ST_IDLE, "booked unit produced no result")
	`EFUA_ASSERT(a_result_matches_store,
		!out_valid_q || busy_q[out_unit_q[UNIT_W-1:0]] == out_done_q,
		"pending result differs from stored busy-until time")

endmodule
